// ----- design/itra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package itra_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 31;
    localparam int BASE_WIDTH          = 5;
    localparam int CHAR_WIDTH          = 7;
    localparam int DIGIT_WIDTH         = 4;
    localparam int DIV_BITS_PER_CYCLE  = 4;

    localparam logic [BASE_WIDTH-1:0]  RADIX_MIN  = 5'd2;
    localparam logic [BASE_WIDTH-1:0]  RADIX_MAX  = 5'd16;
    localparam logic [DIGIT_WIDTH-1:0] DEC_TEN    = 4'd10;
    localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO = 7'h30;
    localparam logic [CHAR_WIDTH-1:0]  ASCII_A    = 7'h41;

    typedef struct packed {
        logic load;
        logic div_step;
        logic rd;
        logic take;
    } t_cmd;

    typedef struct packed {
        logic digit_done;
        logic quot_zero;
        logic last;
    } t_sts;

    function automatic logic [BASE_WIDTH-1:0] sat_radix(input logic [BASE_WIDTH-1:0] base);
        logic [BASE_WIDTH-1:0] r;
        r = base;
        if (base < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (base > RADIX_MAX) begin
            r = RADIX_MAX;
        end
        return r;
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] to_ascii(input logic [DIGIT_WIDTH-1:0] digit);
        logic [CHAR_WIDTH-1:0] c;
        if (digit < DEC_TEN) begin
            c = ASCII_ZERO + CHAR_WIDTH'(digit);
        end else begin
            c = ASCII_A + CHAR_WIDTH'(digit - DEC_TEN);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/itra_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface itra_in_if
    import itra_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic [BASE_WIDTH-1:0]  base;

    modport source (output valid, value, base, input ready);
    modport sink   (input valid, value, base, output ready);
endinterface

interface itra_out_if
    import itra_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CHAR_WIDTH-1:0] ascii_char;
    logic                  last;

    modport source (output valid, ascii_char, last, input ready);
    modport sink   (input valid, ascii_char, last, output ready);
endinterface

`default_nettype wire

// ----- design/itra_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module itra_ctrl
    import itra_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  wire  i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_RD   = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.digit_done && i_sts.quot_zero) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_HOLD;
            end
            S_HOLD: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_sts.last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/itra_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module itra_dp
    import itra_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)(
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  t_cmd                        i_cmd,
    output t_sts                        o_sts,
    input  wire [VALUE_WIDTH-1:0]       i_value,
    input  wire [BASE_WIDTH-1:0]        i_base,
    output logic [CHAR_WIDTH-1:0]       o_ascii_char,
    output logic                        o_last
);

    localparam int PADW  = ((VALUE_WIDTH + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE)
                           * DIV_BITS_PER_CYCLE;
    localparam int NSTEP = PADW / DIV_BITS_PER_CYCLE;
    localparam int STEPW = $clog2(NSTEP);
    localparam int DEPTH = VALUE_WIDTH + 1;
    localparam int IDXW  = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [BASE_WIDTH-1:0]  r_radix;
    logic [PADW-1:0]        r_shift;
    logic [PADW-1:0]        n_shift;
    logic [DIGIT_WIDTH-1:0] r_rem;
    logic [DIGIT_WIDTH-1:0] n_rem;
    logic [STEPW-1:0]       r_step;
    logic [CNTW-1:0]        r_count;
    logic [IDXW-1:0]        r_idx;
    logic [DIGIT_WIDTH-1:0] r_rd_data;
    logic                   r_last;
    logic                   digit_done;

    logic [DIGIT_WIDTH-1:0] r_store [DEPTH];

    // restoring division: dividend bits leave at the top, quotient bits enter at the bottom
    always_comb begin
        logic [PADW-1:0]         sh;
        logic [DIGIT_WIDTH-1:0]  rem;
        logic [BASE_WIDTH-1:0]   t;
        logic                    qb;
        sh  = r_shift;
        rem = r_rem;
        for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
            t  = {rem, sh[PADW-1]};
            qb = (t >= r_radix);
            if (qb) begin
                t = t - r_radix;
            end
            sh  = {sh[PADW-2:0], qb};
            rem = t[DIGIT_WIDTH-1:0];
        end
        n_shift = sh;
        n_rem   = rem;
    end

    assign digit_done       = (r_step == STEPW'(NSTEP - 1));
    assign o_sts.digit_done = digit_done;
    assign o_sts.quot_zero  = (n_shift == '0);
    assign o_sts.last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_step  <= '0;
            r_count <= '0;
        end else if (i_cmd.div_step) begin
            if (digit_done) begin
                r_step <= '0;
                if (r_count < CNTW'(DEPTH)) begin
                    r_count <= r_count + 1'b1;
                end
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_radix <= sat_radix(i_base);
            r_shift <= PADW'(i_value);
            r_rem   <= '0;
        end else if (i_cmd.div_step) begin
            r_shift <= n_shift;
            r_rem   <= digit_done ? '0 : n_rem;
        end
        // index of the most recent digit = most significant one
        if (i_cmd.div_step && digit_done && r_count < CNTW'(DEPTH)) begin
            r_idx <= r_count[IDXW-1:0];
        end else if (i_cmd.take) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.rd) begin
            r_last <= (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && digit_done && r_count < CNTW'(DEPTH)) begin
            r_store[r_count[IDXW-1:0]] <= n_rem;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_store[r_idx];
        end
    end

    assign o_ascii_char = to_ascii(r_rd_data);
    assign o_last       = r_last;

endmodule

`default_nettype wire

// ----- design/integer_to_radix_ascii.sv -----
// Integer to radix ASCII converter.
// Input channel i_in (valid/ready): value and base. Base 0..1 is taken as 2,
// 17..31 as 16. The input is ready only while the block is idle; a word is
// taken at a clock edge where valid and ready are both high.
// Output channel o_out (valid/ready): one word per digit, most significant
// first, ascii_char '0'-'9' / 'A'-'F', last set on the least significant digit.
// A zero value gives the single digit '0'.
// Timing: the divider retires 4 quotient bits a cycle and computes all digits,
// least significant first, into the digit memory before any is emitted. Each
// digit is then read from the digit memory and held on the output until it
// is accepted.
// A stalled receiver holds the current word stable; no new input is taken
// until the word with last is accepted.
// Reset (synchronous, active low) returns to idle with no output pending; the
// digit memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_ascii
    import itra_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)(
    input wire        i_clk,
    input wire        i_rst_n,
    itra_in_if.sink   i_in,
    itra_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;

    itra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    itra_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_value      (i_in.value),
        .i_base       (i_in.base),
        .o_ascii_char (o_out.ascii_char),
        .o_last       (o_out.last)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a digit is pending");

    a_more_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> !i_in.ready)
        else $error("returned to idle before the last digit");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> i_in.ready)
        else $error("not idle after the last digit");

    a_div_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> !o_out.valid)
        else $error("output valid while dividing");

endmodule

`default_nettype wire
